// ===== rtl/core/fsc_pkg.sv =====
// Shared types, constants and cosine-table function for the FIR soft-clip filter.
`default_nettype none

package fsc_pkg;

  // Stream layout
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned CIDX_W    = 4;

  // Transaction kinds carried in tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEFF  = 1'b1;

  // Rounding from Q14
  localparam int unsigned FRAC_W    = 14;
  localparam int unsigned ROUND_ADD = 8192;

  // Soft clipper
  localparam int unsigned CLIP_MAX_AMP = 32767;
  localparam int unsigned CLIP_THRESH  = 29490;
  localparam int unsigned CLIP_WINDOW  = CLIP_MAX_AMP - CLIP_THRESH;
  localparam int unsigned OVER_W       = 12;
  localparam int unsigned MAG_W        = 17;

  // Quarter-cosine table, Q15
  localparam int unsigned COS_TABLE_DEPTH = 256;
  localparam int unsigned COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned COS_W           = 15;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [7]  = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182};

  // idx = floor(over * DEPTH / WINDOW) by reciprocal multiply plus one correction
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 21;
  localparam longint unsigned RECIP   =
    (longint'(COS_TABLE_DEPTH) << RECIP_SHIFT) / longint'(CLIP_WINDOW);
  localparam int unsigned REM_W       = 21;

  // Shared multiplier operand widths
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 22;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_MAG,
    S_DIV,
    S_FIX,
    S_COS,
    S_SCALE
  } fsc_state_e;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } fsc_mac_ctrl_t;

  // One Q15 entry of cos(pi/2 * k / DEPTH), Taylor series in Q30
  function automatic logic [15:0] cos_entry(input int unsigned k);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    theta = (64'(k) * HALF_PI_Q30) / 64'(COS_TABLE_DEPTH);
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = signed'(term);
    for (int n = 0; n < 7; n++) begin
      term = ((term * t2) >> 30) / TAYLOR_DIV[n];
      if ((n & 1) == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    q = (unsigned'(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fsc_mac.sv =====
// Shared multiplier with product register and wide accumulator.
`default_nettype none

module fsc_mac
  import fsc_pkg::*;
#(
  parameter int unsigned ACC_W = 36
) (
  input  wire                              clk_i,
  input  wire fsc_mac_ctrl_t               ctrl_i,
  input  wire logic signed [MUL_A_W-1:0]   op_a_i,
  input  wire logic signed [MUL_B_W-1:0]   op_b_i,
  output logic signed [MUL_P_W-1:0]        prod_o,
  output logic signed [ACC_W-1:0]          acc_o
);

  logic signed [MUL_P_W-1:0] prod_q;
  logic signed [ACC_W-1:0]   acc_q;

  // Registered product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  // Accumulate tap products; each fits the accumulator width
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + $signed(prod_q[ACC_W-1:0]);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/fir_filter_soft_clip.sv =====
// Top level: TAPS-tap FIR over a circular delay line with a cosine soft clipper.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: sample_in, coeff_index, coeff_value
//                                                tuser: cmd
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: sample_out; tuser: clipped
//
//  A sample transaction keeps the block busy after acceptance (one multiply-accumulate
//  per tap through the one shared multiplier, pipeline drain, then rounding and soft
//  clipping in S_ROUND, S_MAG, S_DIV, S_FIX, S_COS, S_SCALE); no new transaction is
//  taken until it is back in S_IDLE. A coefficient write is taken in S_IDLE.
//  Reset clears delay line, coefficients (through per-entry valid bits) and pointers.
//  A finished result waits in the output register; the next sample is accepted
//  meanwhile and only its final step stalls if the result is still not taken.
`default_nettype none

module fir_filter_soft_clip
  import fsc_pkg::*;
#(
  parameter int unsigned TAPS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] sample_in, [19:16] coeff_index, [35:20] coeff_value, [39:36] zero
  input  wire [S_TDATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  wire [0:0]              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // [15:0] sample_out
  output logic [M_TDATA_W-1:0]   m_axis_tdata,
  // [0] clipped
  output logic [0:0]             m_axis_tuser
);

  localparam int unsigned PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned ACC_W = 32 + PTR_W;
  localparam int unsigned RND_W = ACC_W + 1;
  localparam int unsigned Y_W   = RND_W - FRAC_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS - 1);

  // Input unpacking
  logic                     in_cmd;
  logic signed [SMP_W-1:0]  in_sample;
  logic [CIDX_W-1:0]        in_cidx;
  logic signed [SMP_W-1:0]  in_cval;
  logic                     accept;
  logic                     smp_acc;
  logic                     cf_wr;
  logic [PTR_W-1:0]         cf_waddr;

  assign in_cmd    = s_axis_tuser[0];
  assign in_sample = $signed(s_axis_tdata[15:0]);
  assign in_cidx   = s_axis_tdata[19:16];
  assign in_cval   = $signed(s_axis_tdata[35:20]);
  assign accept    = s_axis_tvalid & s_axis_tready;
  assign smp_acc   = accept & (in_cmd == CMD_SAMPLE);
  assign cf_wr     = accept & (in_cmd == CMD_COEFF) & (32'(in_cidx) < 32'(TAPS));
  assign cf_waddr  = PTR_W'(in_cidx);

  // Sequencer and pointer state
  fsc_state_e        state_q, state_d;
  logic [PTR_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic              rd_vld_q;
  logic              mul_vld_q;
  logic              out_vld_q, out_vld_d;
  logic              out_load;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Delay line and coefficient store
  logic signed [SMP_W-1:0] dl_mem [TAPS];
  logic signed [SMP_W-1:0] cf_mem [TAPS];
  logic [TAPS-1:0]         dl_vld_q;
  logic [TAPS-1:0]         cf_vld_q;
  logic signed [SMP_W-1:0] dl_rd_q;
  logic signed [SMP_W-1:0] cf_rd_q;
  logic                    dl_rv_q;
  logic                    cf_rv_q;

  always_ff @(posedge clk_i) begin
    if (cf_wr) begin
      cf_mem[cf_waddr] <= in_cval;
    end
    if (smp_acc) begin
      dl_mem[wp_q] <= in_sample;
    end
    cf_rd_q <= cf_mem[cnt_q];
    dl_rd_q <= dl_mem[rp_q];
  end

  // Entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q  <= '0;
      cf_vld_q  <= '0;
      dl_rv_q   <= 1'b0;
      cf_rv_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      if (cf_wr) begin
        cf_vld_q[cf_waddr] <= 1'b1;
      end
      if (smp_acc) begin
        dl_vld_q[wp_q] <= 1'b1;
      end
      cf_rv_q   <= cf_vld_q[cnt_q];
      dl_rv_q   <= dl_vld_q[rp_q];
      rd_vld_q  <= (state_q == S_MAC);
      mul_vld_q <= rd_vld_q;
    end
  end

  // Cosine table, constant logic
  logic [15:0] cos_tbl [COS_TABLE_DEPTH];
  for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_cos
    assign cos_tbl[k] = cos_entry(k);
  end

  // Shared multiply-accumulate unit
  fsc_mac_ctrl_t                mac_ctrl;
  logic signed [MUL_A_W-1:0]    op_a;
  logic signed [MUL_B_W-1:0]    op_b;
  logic signed [MUL_P_W-1:0]    prod;
  logic signed [ACC_W-1:0]      acc;

  fsc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Post-processing registers
  logic signed [SMP_W-1:0]  y_q;
  logic                     hit_q;
  logic [OVER_W-1:0]        over_q;
  logic [COS_IDX_W:0]       idx_q;
  logic signed [SMP_W-1:0]  out_data_q;
  logic                     out_clip_q;

  // Rounding and saturation
  logic signed [RND_W-1:0]  rnd;
  logic signed [Y_W-1:0]    ysh;
  logic signed [SMP_W-1:0]  y_sat;

  always_comb begin
    rnd = RND_W'(acc) + RND_W'(ROUND_ADD);
    ysh = Y_W'(rnd >>> FRAC_W);
    if (ysh > Y_W'(32767)) begin
      y_sat = 16'sd32767;
    end else if (ysh < -Y_W'(32768)) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = ysh[SMP_W-1:0];
    end
  end

  // Magnitude and overshoot
  logic signed [MAG_W-1:0]  y_ext;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         ov;
  logic                     hit_d;
  logic [OVER_W-1:0]        over_d;

  always_comb begin
    y_ext  = MAG_W'(y_q);
    mag    = y_ext[MAG_W-1] ? unsigned'(-y_ext) : unsigned'(y_ext);
    hit_d  = (mag >= MAG_W'(CLIP_THRESH));
    ov     = mag - MAG_W'(CLIP_THRESH);
    over_d = (ov > MAG_W'(CLIP_WINDOW)) ? OVER_W'(CLIP_WINDOW) : ov[OVER_W-1:0];
  end

  // Table index correction after reciprocal multiply
  logic [COS_IDX_W:0]  q0;
  logic [REM_W-1:0]    rem;
  logic [COS_IDX_W:0]  idx_d;

  always_comb begin
    q0    = prod[RECIP_SHIFT+COS_IDX_W:RECIP_SHIFT];
    rem   = (REM_W'(over_q) << COS_IDX_W) - REM_W'(q0) * REM_W'(CLIP_WINDOW);
    idx_d = q0 + ((rem >= REM_W'(CLIP_WINDOW)) ? 1'b1 : 1'b0);
  end

  // Cosine lookup, zero past the table end
  logic [COS_W-1:0] cos_val;
  assign cos_val = idx_q[COS_IDX_W] ? '0 : cos_tbl[idx_q[COS_IDX_W-1:0]][COS_W-1:0];

  // Final scaling and sign
  logic [26:0]              sc;
  logic [SMP_W-1:0]         m_mag;
  logic signed [SMP_W-1:0]  res;
  logic                     clip;

  always_comb begin
    sc    = prod[26:0] + 27'd16384;
    m_mag = SMP_W'(CLIP_THRESH) + SMP_W'(sc[26:15]);
    if (hit_q) begin
      res = y_q[SMP_W-1] ? -$signed(m_mag) : $signed(m_mag);
    end else begin
      res = y_q;
    end
    clip = hit_q && (res != y_q);
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (smp_acc) state_d = S_MAC;
      S_MAC:   if (cnt_q == PTR_LAST) state_d = S_DRAIN;
      S_DRAIN: if (!rd_vld_q && !mul_vld_q) state_d = S_ROUND;
      S_ROUND: state_d = S_MAG;
      S_MAG:   state_d = S_DIV;
      S_DIV:   state_d = S_FIX;
      S_FIX:   state_d = S_COS;
      S_COS:   state_d = S_SCALE;
      S_SCALE: if (!out_vld_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready    = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.acc_clr = 1'b0;
    mac_ctrl.acc_en  = mul_vld_q;
    op_a             = '0;
    op_b             = '0;
    out_load         = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        // Clear the accumulator as a sample transaction is taken
        mac_ctrl.acc_clr = s_axis_tvalid & (in_cmd == CMD_SAMPLE);
      end
      S_DIV: begin
        mac_ctrl.mul_en = 1'b1;
        op_a = $signed(MUL_A_W'(over_q));
        op_b = $signed(MUL_B_W'(RECIP));
      end
      S_COS: begin
        mac_ctrl.mul_en = 1'b1;
        op_a = $signed(MUL_A_W'(over_q));
        op_b = $signed(MUL_B_W'(cos_val));
      end
      S_SCALE: begin
        out_load = !out_vld_q || m_axis_tready;
      end
      default: begin
      end
    endcase
    // Tap products from the registered memory reads
    if (rd_vld_q) begin
      mac_ctrl.mul_en = 1'b1;
      op_a = cf_rv_q ? MUL_A_W'(cf_rd_q) : '0;
      op_b = dl_rv_q ? MUL_B_W'(dl_rd_q) : '0;
    end
  end

  // Pointer and counter updates
  always_comb begin
    cnt_d = cnt_q;
    wp_d  = wp_q;
    rp_d  = rp_q;
    if (smp_acc) begin
      cnt_d = '0;
      wp_d  = ptr_inc(wp_q);
      rp_d  = ptr_inc(wp_q);
    end else if (state_q == S_MAC) begin
      cnt_d = cnt_q + 1'b1;
      rp_d  = ptr_inc(rp_q);
    end
  end

  // Output register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      wp_q      <= '0;
      rp_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROUND) begin
      y_q <= y_sat;
    end
    if (state_q == S_MAG) begin
      hit_q  <= hit_d;
      over_q <= over_d;
    end
    if (state_q == S_FIX) begin
      idx_q <= idx_d;
    end
    if (out_load) begin
      out_data_q <= res;
      out_clip_q <= clip;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_clip_q;

  // A new result only comes out of the final scaling step
  a_out_from_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_SCALE))
    else $error("result appeared outside the scaling step");

  // The accumulator is settled before rounding reads it
  a_acc_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (!rd_vld_q && !mul_vld_q))
    else $error("rounding started with taps still in flight");

  // A clipped result stays at or above the threshold in magnitude
  a_clip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_clip_q) |->
      (out_data_q >= $signed(SMP_W'(CLIP_THRESH)) ||
       out_data_q <= -$signed(SMP_W'(CLIP_THRESH))))
    else $error("clipped result below threshold");

  // Input is refused while a sample is being filtered
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC || state_q == S_DRAIN) |-> !s_axis_tready)
    else $error("input accepted during filtering");

endmodule

`default_nettype wire
